// ===== rtl/sfr_pkg.sv =====
// Shared types, codes and constants of the serial frame receiver.
package sfr_pkg;

  localparam int MAX_FRAME_LEN_DEF = 32;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;
  localparam int LEN_W             = 7;
  localparam int IDX_OUT_W         = 6;
  localparam int SILENCE_W         = 17;

  localparam logic [LEN_W-1:0]     MIN_LEN_FLOOR = 7'd4;
  localparam logic [SILENCE_W-1:0] SILENCE_MAX   = 17'h1FFFF;

  localparam logic [7:0]  HEADER_RST    = 8'h42;
  localparam logic [6:0]  MIN_LEN_RST   = 7'd4;
  localparam logic [7:0]  CTRL_ADDR_RST = 8'd1;
  localparam logic [15:0] TIMEOUT_RST   = 16'd3000;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_ADDR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd3;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [1:0] EV_GOOD      = 2'd0;
  localparam logic [1:0] EV_CSUM_ERR  = 2'd1;
  localparam logic [1:0] EV_LINK_LOST = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [6:0]  min_frame_len;
    logic [7:0]  control_address;
    logic [15:0] link_timeout;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  frame_byte;
    logic [5:0]  byte_index;
    logic        last;
    logic [7:0]  address;
    logic [6:0]  frame_length;
    logic        is_control;
    logic [31:0] speed_bits;
    logic [15:0] servo_value;
    logic        connected;
  } out_item_t;

endpackage

// ===== rtl/sfr_cfg_regs.sv =====
// Configuration register file of the serial frame receiver.
module sfr_cfg_regs
  import sfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte     <= HEADER_RST;
      cfg.min_frame_len   <= MIN_LEN_RST;
      cfg.control_address <= CTRL_ADDR_RST;
      cfg.link_timeout    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HEADER:    cfg.header_byte     <= cfg_wdata[7:0];
        REG_MIN_LEN:   cfg.min_frame_len   <= cfg_wdata[6:0];
        REG_CTRL_ADDR: cfg.control_address <= cfg_wdata[7:0];
        REG_TIMEOUT:   cfg.link_timeout    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/serial_frame_receiver_with_link_watchdog.sv =====
// Top level: frame parser with byte store, checksum, emission and link watchdog.
//
//   channel  | signals                     | moves
//   ---------+-----------------------------+------------------------------------
//   in       | in_valid, in_ready, in_data | one byte or tick request per beat
//   out      | out_valid, out_ready, out_data | one result item per beat
//   cfg      | cfg_we, cfg_addr, cfg_wdata | register write, no wait
//
// A byte or tick is taken whenever the receiver is idle and the output register is free.
// A good frame of length L then reads the frame store through its single read port,
// one byte per cycle unless the output stalls; no request is taken until all L are sent.
// Synchronous reset clears control state; the frame store needs no clearing pass.
// A stalled output holds the result and blocks new requests.
module serial_frame_receiver_with_link_watchdog
  import sfr_pkg::*;
#(
  parameter int MAX_FRAME_LEN = MAX_FRAME_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_FRAME_LEN);
  localparam logic [7:0] MAX_LEN_B = 8'(MAX_FRAME_LEN);

  cfg_t cfg;

  sfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  state_t                 state;
  state_t                 state_next;
  logic                   in_frame;
  logic [LEN_W-1:0]       wr_idx;
  logic [LEN_W-1:0]       len_q;
  logic [7:0]             addr_q;
  logic [7:0]             sum_q;
  logic [31:0]            speed_q;
  logic [15:0]            servo_q;
  logic                   ctl_q;
  logic                   link_up;
  logic [SILENCE_W-1:0]   silence;
  logic [AW-1:0]          rd_idx;
  logic                   pend;
  logic [7:0]             rd_data;
  logic [7:0]             mem [MAX_FRAME_LEN];

  logic                   accept;
  logic                   out_free;
  logic [7:0]             b;
  logic                   is_byte;
  logic                   hdr_hit;
  logic                   len_bad;
  logic                   done;
  logic                   sum_ok;
  logic                   good_done;
  logic                   ctl_now;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [SILENCE_W-1:0]   silence_inc;
  logic                   lost;
  logic                   emit_take;
  logic                   emit_last;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   lost_load;
  logic                   err_load;
  out_item_t              lost_item;
  out_item_t              err_item;
  out_item_t              good_item;

  assign out_free    = !out_valid || out_ready;
  assign accept      = in_valid && in_ready;
  assign b           = in_data.rx_byte;
  assign is_byte     = (in_data.action == ACT_BYTE);
  assign hdr_hit     = !in_frame && (b == cfg.header_byte);
  assign len_bad     = (b > MAX_LEN_B) || (b < {1'b0, cfg.min_frame_len})
                       || (b < {1'b0, MIN_LEN_FLOOR});
  assign done        = in_frame && (wr_idx >= 7'd3) && ((wr_idx + 7'd1) == len_q);
  assign sum_ok      = (sum_q == b);
  assign good_done   = accept && is_byte && done && sum_ok;
  assign ctl_now     = (addr_q == cfg.control_address);
  assign mem_we      = accept && is_byte && (in_frame || hdr_hit);
  assign mem_waddr   = in_frame ? wr_idx[AW-1:0] : '0;
  assign silence_inc = (silence == SILENCE_MAX) ? silence : silence + 1'b1;
  assign lost        = silence_inc > {1'b0, cfg.link_timeout};
  assign lost_load   = accept && !is_byte && link_up && lost;
  assign err_load    = accept && is_byte && done && !sum_ok;

  assign emit_take = (state == ST_EMIT) && pend && out_free;
  assign emit_last = (LEN_W'(rd_idx) == (len_q - 7'd1));
  assign rd_en     = (state == ST_EMIT) && (!pend || (emit_take && !emit_last));
  assign rd_addr   = pend ? rd_idx + 1'b1 : rd_idx;

  always_comb begin
    lost_item              = '0;
    lost_item.event_res    = EV_LINK_LOST;
    lost_item.last         = 1'b1;
    err_item               = '0;
    err_item.event_res     = EV_CSUM_ERR;
    err_item.last          = 1'b1;
    err_item.address       = addr_q;
    err_item.frame_length  = len_q;
    err_item.is_control    = ctl_now;
    err_item.connected     = link_up;
    good_item.event_res    = EV_GOOD;
    good_item.frame_byte   = rd_data;
    good_item.byte_index   = IDX_OUT_W'(rd_idx);
    good_item.last         = emit_last;
    good_item.address      = addr_q;
    good_item.frame_length = len_q;
    good_item.is_control   = ctl_q;
    good_item.speed_bits   = ctl_q ? speed_q : '0;
    good_item.servo_value  = ctl_q ? servo_q : '0;
    good_item.connected    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = out_free;
        if (good_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_take && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= b;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (lost_load || err_load || emit_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (lost_load) begin
        out_data <= lost_item;
      end else if (err_load) begin
        out_data <= err_item;
      end else if (emit_take) begin
        out_data <= good_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      wr_idx    <= '0;
      link_up   <= 1'b0;
      silence   <= '0;
      pend      <= 1'b0;
    end else begin
      if (accept && !is_byte) begin
        if (link_up) begin
          silence <= silence_inc;
          if (lost) begin
            link_up <= 1'b0;
          end
        end
      end else if (accept) begin
        if (!in_frame) begin
          if (hdr_hit) begin
            in_frame <= 1'b1;
            wr_idx   <= 7'd1;
            sum_q    <= b;
            speed_q  <= '0;
            servo_q  <= '0;
          end
        end else if (wr_idx == 7'd1) begin
          addr_q <= b;
          sum_q  <= sum_q + b;
          wr_idx <= 7'd2;
        end else if (wr_idx == 7'd2) begin
          if (len_bad) begin
            in_frame <= 1'b0;
            wr_idx   <= '0;
          end else begin
            len_q  <= b[LEN_W-1:0];
            sum_q  <= sum_q + b;
            wr_idx <= 7'd3;
          end
        end else begin
          case (wr_idx)
            7'd3: speed_q[7:0]   <= b;
            7'd4: speed_q[15:8]  <= b;
            7'd5: speed_q[23:16] <= b;
            7'd6: speed_q[31:24] <= b;
            7'd7: servo_q[7:0]   <= b;
            7'd8: servo_q[15:8]  <= b;
            default: ;
          endcase
          if (done) begin
            in_frame <= 1'b0;
            wr_idx   <= '0;
            ctl_q    <= ctl_now;
            rd_idx   <= '0;
            pend     <= 1'b0;
            if (sum_ok) begin
              link_up <= 1'b1;
              silence <= '0;
            end
          end else begin
            sum_q  <= sum_q + b;
            wr_idx <= wr_idx + 7'd1;
          end
        end
      end

      if (state == ST_EMIT) begin
        if (!pend) begin
          pend <= 1'b1;
        end else if (emit_take) begin
          if (emit_last) begin
            pend <= 1'b0;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
      end
    end
  end

  a_lost_drops_link: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res == EV_LINK_LOST) |-> !link_up)
    else $error("link lost item while link still up");

  a_good_needs_link: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res == EV_GOOD) |-> link_up)
    else $error("frame byte item while link down");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res == EV_GOOD && out_data.last)
      |-> (out_data.byte_index == IDX_OUT_W'(out_data.frame_length - 7'd1)))
    else $error("last frame byte at wrong offset");

  a_no_request_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |=> (!$past(accept)))
    else $error("request taken during emission");

endmodule

// ===== tb/sv/serial_frame_receiver_with_link_watchdog_tb.sv =====
// Self-checking testbench: frame parsing, checksum, emission and link watchdog.
`timescale 1ns / 100ps

module serial_frame_receiver_with_link_watchdog_tb;
  import sfr_pkg::*;

  localparam int FRAME_CAP    = MAX_FRAME_LEN_DEF;
  localparam int SETTLE_TICKS = 2 * FRAME_CAP + 8;
  localparam int PHASE_ITEMS  = 16;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  serial_frame_receiver_with_link_watchdog dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  logic [7:0]           hdr_value       = HEADER_RST;
  logic [6:0]           min_len_value   = MIN_LEN_RST;
  logic [7:0]           ctrl_addr_value = CTRL_ADDR_RST;
  logic [15:0]          timeout_value   = TIMEOUT_RST;

  logic                 frame_open  = 1'b0;
  int unsigned          fill_pos    = 0;
  logic [7:0]           frame_bytes [0:FRAME_CAP-1];
  logic                 link_alive  = 1'b0;
  logic [SILENCE_W-1:0] quiet_ticks = '0;

  out_item_t            frame_events_due[$];
  logic [7:0]           frame_body[$];
  int unsigned          mismatches     = 0;
  int unsigned          requests_sent  = 0;
  int unsigned          send_idle_pct  = 20;
  int unsigned          recv_idle_pct  = 85;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAIL serial_frame_receiver_with_link_watchdog");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("ERROR %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (frame_events_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = frame_events_due.pop_front();
        check_field("event_res", out_data.event_res, want.event_res);
        check_field("frame_byte", out_data.frame_byte, want.frame_byte);
        check_field("byte_index", out_data.byte_index, want.byte_index);
        check_field("last", out_data.last, want.last);
        check_field("address", out_data.address, want.address);
        check_field("frame_length", out_data.frame_length, want.frame_length);
        check_field("is_control", out_data.is_control, want.is_control);
        check_field("speed_bits", out_data.speed_bits, want.speed_bits);
        check_field("servo_value", out_data.servo_value, want.servo_value);
        check_field("connected", out_data.connected, want.connected);
      end
    end
  end

  function automatic logic [7:0] stored_byte(input int unsigned pos, input int unsigned len);
    if (pos >= len || pos >= FRAME_CAP) return 8'h00;
    return frame_bytes[pos];
  endfunction

  // Advance the frame parser and watchdog by one request; queue the events it raises.
  task automatic parse_request(input in_item_t req);
    out_item_t   ev;
    logic [7:0]  b;
    logic [7:0]  sum;
    logic [7:0]  adr;
    logic        ctl;
    logic [31:0] spd;
    logic [15:0] srv;
    int unsigned len;
    int unsigned i;
    b = req.rx_byte;
    if (req.action == ACT_TICK) begin
      if (!link_alive) return;
      if (quiet_ticks != SILENCE_MAX) quiet_ticks++;
      if (quiet_ticks > {1'b0, timeout_value}) begin
        link_alive = 1'b0;
        ev = '0;
        ev.event_res = EV_LINK_LOST;
        ev.last = 1'b1;
        frame_events_due.push_back(ev);
      end
      return;
    end
    if (!frame_open) begin
      if (b == hdr_value) begin
        frame_open = 1'b1;
        frame_bytes[0] = b;
        frame_bytes[2] = {1'b0, min_len_value};
        fill_pos = 1;
      end
      return;
    end
    if (fill_pos == 2) begin
      frame_bytes[2] = b;
      fill_pos = 3;
      if (b > FRAME_CAP || b < min_len_value || b < MIN_LEN_FLOOR) begin
        frame_bytes[2] = {1'b0, min_len_value};
        fill_pos = 0;
        frame_open = 1'b0;
        return;
      end
    end else if (fill_pos < FRAME_CAP) begin
      frame_bytes[fill_pos] = b;
      fill_pos++;
    end
    if (fill_pos >= 3 && (fill_pos >= FRAME_CAP || fill_pos >= frame_bytes[2])) begin
      fill_pos = 0;
      frame_open = 1'b0;
      len = (frame_bytes[2] > FRAME_CAP) ? FRAME_CAP : frame_bytes[2];
      adr = frame_bytes[1];
      ctl = (adr == ctrl_addr_value);
      sum = '0;
      for (i = 0; i + 1 < len; i++) sum += frame_bytes[i];
      ev = '0;
      ev.address = adr;
      ev.frame_length = len[6:0];
      ev.is_control = ctl;
      ev.last = 1'b1;
      if (sum != frame_bytes[len-1]) begin
        ev.event_res = EV_CSUM_ERR;
        ev.connected = link_alive;
        frame_events_due.push_back(ev);
        return;
      end
      link_alive = 1'b1;
      quiet_ticks = '0;
      spd = '0;
      srv = '0;
      if (ctl) begin
        spd = {stored_byte(6, len), stored_byte(5, len), stored_byte(4, len),
               stored_byte(3, len)};
        srv = {stored_byte(8, len), stored_byte(7, len)};
      end
      for (i = 0; i < len; i++) begin
        ev.event_res = EV_GOOD;
        ev.frame_byte = frame_bytes[i];
        ev.byte_index = i[5:0];
        ev.last = (i + 1 == len);
        ev.speed_bits = spd;
        ev.servo_value = srv;
        ev.connected = 1'b1;
        frame_events_due.push_back(ev);
      end
    end
  endtask

  task automatic send_request(input logic act, input logic [7:0] value);
    in_item_t req;
    req.action = act;
    req.rx_byte = value;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    parse_request(req);
    requests_sent++;
  endtask

  task automatic send_tick();
    send_request(ACT_TICK, 8'($urandom_range(255)));
  endtask

  // Bytes from offset 3 up to the checksum come from frame_body, then random; a bad
  // length field sends only the first three bytes.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] len_field,
                            input bit corrupt);
    logic [7:0]  bytes_out[$];
    logic [7:0]  sum;
    int unsigned n;
    bytes_out.push_back(hdr_value);
    bytes_out.push_back(addr);
    bytes_out.push_back(len_field);
    if (len_field >= MIN_LEN_FLOOR && len_field >= min_len_value && len_field <= FRAME_CAP)
    begin
      for (n = 3; n + 1 < len_field; n++) begin
        if (frame_body.size() != 0) bytes_out.push_back(frame_body.pop_front());
        else bytes_out.push_back(8'($urandom_range(255)));
      end
      sum = '0;
      foreach (bytes_out[k]) sum += bytes_out[k];
      if (corrupt) sum ^= 8'($urandom_range(1, 255));
      bytes_out.push_back(sum);
    end
    frame_body.delete();
    foreach (bytes_out[k]) send_request(ACT_BYTE, bytes_out[k]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (frame_events_due.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HEADER:    hdr_value = value[7:0];
      REG_MIN_LEN:   min_len_value = value[6:0];
      REG_CTRL_ADDR: ctrl_addr_value = value[7:0];
      REG_TIMEOUT:   timeout_value = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_length(input bit bad);
    int unsigned lo;
    int unsigned hi;
    lo = (min_len_value < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len_value;
    if (bad) begin
      if ($urandom_range(1)) return 8'($urandom_range(lo - 1));
      return 8'($urandom_range(FRAME_CAP + 1, 255));
    end
    if ($urandom_range(9) == 0) return 8'(FRAME_CAP);
    hi = (lo + 8 > FRAME_CAP) ? FRAME_CAP : lo + 8;
    return 8'($urandom_range(lo, hi));
  endfunction

  task automatic test_reset_defaults();
    send_tick();
    send_request(ACT_BYTE, 8'hFF);
    send_request(ACT_BYTE, 8'h00);
    send_frame(CTRL_ADDR_RST, 8'd4, 1'b0);
    send_frame(8'h80, 8'd5, 1'b0);
    wait_idle();
  endtask

  task automatic test_frame_cases();
    frame_body = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h42};
    send_frame(ctrl_addr_value, 8'd9, 1'b0);
    send_frame(8'h7E, 8'd6, 1'b1);
    send_frame(ctrl_addr_value, 8'd5, 1'b1);
    frame_body = '{8'h42, 8'h42, 8'h42};
    send_frame(hdr_value, 8'd7, 1'b0);
    send_frame(8'h10, 8'd33, 1'b0);
    send_frame(8'h10, 8'hFF, 1'b0);
    send_frame(8'h10, 8'd3, 1'b0);
    send_frame(8'h10, 8'd0, 1'b0);
    wait_idle();
  endtask

  task automatic test_length_limits();
    write_register(REG_MIN_LEN, 16'd64);
    send_frame(ctrl_addr_value, 8'd32, 1'b0);
    wait_idle();
    write_register(REG_MIN_LEN, 16'd32);
    send_frame(ctrl_addr_value, 8'd32, 1'b0);
    send_frame(8'h55, 8'd31, 1'b0);
    wait_idle();
    write_register(REG_MIN_LEN, 16'd4);
  endtask

  task automatic test_watchdog();
    write_register(REG_TIMEOUT, 16'd1);
    send_frame(8'h20, 8'd4, 1'b0);
    send_tick();
    send_tick();
    send_tick();
    send_frame(8'h21, 8'd4, 1'b1);
    send_frame(8'h22, 8'd4, 1'b0);
    send_tick();
    send_tick();
    wait_idle();
    write_register(REG_TIMEOUT, 16'hFFFF);
    send_frame(8'h23, 8'd4, 1'b0);
    repeat (4) send_tick();
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [7:0] hdr, input logic [6:0] min_len,
                                     input logic [7:0] ctrl, input logic [15:0] timeout);
    int unsigned start_count;
    int unsigned kind;
    logic [7:0]  addr;
    wait_idle();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_register(REG_HEADER, {8'h00, hdr});
    write_register(REG_MIN_LEN, {9'h000, min_len});
    write_register(REG_CTRL_ADDR, {8'h00, ctrl});
    write_register(REG_TIMEOUT, timeout);
    start_count = requests_sent;
    while (requests_sent - start_count < PHASE_ITEMS) begin
      kind = $urandom_range(99);
      addr = $urandom_range(1) ? ctrl_addr_value : 8'($urandom_range(255));
      if (kind < 70) begin
        send_frame(addr, pick_length(1'b0), $urandom_range(7) == 0);
      end else if (kind < 78) begin
        send_frame(addr, pick_length(1'b1), 1'b0);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 8)) send_tick();
      end else if (kind < 95) begin
        send_request(ACT_BYTE, hdr_value);
        repeat ($urandom_range(1, 3)) send_request(ACT_BYTE, 8'($urandom_range(255)));
      end else begin
        send_request(ACT_BYTE, 8'($urandom_range(255)));
      end
    end
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
    frame_bytes[2] = {1'b0, MIN_LEN_RST};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_frame_cases();
    test_length_limits();
    test_watchdog();
    test_random_traffic(20, 85, 8'h00, 7'd4, 8'h00, 16'd5);
    test_random_traffic(85, 20, 8'hFF, 7'd10, 8'hFF, 16'hFFFF);
    test_random_traffic(0, 0, 8'($urandom_range(255)), 7'd4, 8'($urandom_range(255)),
                        16'($urandom_range(2, 12)));

    wait_idle();
    if (frame_events_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", frame_events_due.size()));
    if (mismatches == 0) begin
      $display("PASS serial_frame_receiver_with_link_watchdog");
    end else begin
      $display("FAIL serial_frame_receiver_with_link_watchdog");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sfr_pkg.sv
rtl/sfr_cfg_regs.sv
rtl/serial_frame_receiver_with_link_watchdog.sv
tb/sv/serial_frame_receiver_with_link_watchdog_tb.sv
